FILE: rtl/a2m_pkg.sv
// Shared types and constants for the ADC code to millivolt converter.
package a2m_pkg;

    localparam int A2M_SEGMENTS = 3;
    localparam int A2M_POINTS   = 4;
    localparam int CODE_W       = 24;
    localparam int MV_W         = 16;
    localparam int IDX_W        = 3;
    localparam int PT_W         = 2;
    localparam int PROD_W       = CODE_W + MV_W;
    localparam int QBITS        = MV_W;
    localparam int DIV_BITS     = 2;
    localparam int DIV_STAGES   = QBITS / DIV_BITS;
    localparam int PIPE_STAGES  = 4 + DIV_STAGES;

    localparam logic [MV_W-1:0]  MV_TOP      = 16'hFFFF;
    localparam logic [IDX_W-1:0] REG_MV_BASE = 3'd4;

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [MV_W-1:0]   mv_t;

    typedef struct packed {
        logic below;
        logic above;
        logic neg;
        mv_t  lo_mv;
    } ctrl_t;

    typedef struct packed {
        ctrl_t ctrl;
        code_t span;
        code_t rem;
        mv_t   qn;
    } div_t;

endpackage

FILE: rtl/adc_to_millivolt_piecewise_linear.sv
// Top level: ADC code to millivolts by piecewise linear interpolation.
//
//  channel   signals                                   direction
//  command   start, busy, adc_code                     in (busy out)
//  result    done, millivolts                          out
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data in (cfg_ready out)
//
// One sample is taken every cycle; busy stays low. Each result is computed
// in registered steps: segment search, operand setup, multiply, eight
// divider stages of two quotient bits, final add. The divider pipeline sets
// the latency. Reset clears the calibration table and all valid bits. The
// receiver cannot stall, so nothing holds.
module adc_to_millivolt_piecewise_linear #(
    parameter int SEGMENTS = a2m_pkg::A2M_SEGMENTS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [23:0]             adc_code,
    output logic                    done,
    output logic [15:0]             millivolts,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [2:0]              cfg_index,
    input  logic [23:0]             cfg_data
);
    import a2m_pkg::*;

    code_t cal_code [A2M_POINTS];
    mv_t   cal_mv   [A2M_POINTS];

    logic  fr_valid;
    ctrl_t fr_ctrl;
    code_t fr_off;
    code_t fr_span;
    mv_t   fr_dmv;

    logic                s3_valid_reg;
    ctrl_t               s3_ctrl_reg;
    code_t               s3_span_reg;
    logic [PROD_W-1:0]   s3_prod_reg;

    logic  chain_valid [DIV_STAGES+1];
    div_t  chain_data  [DIV_STAGES+1];

    logic  done_reg;
    mv_t   millivolts_reg;
    mv_t   mv_next;
    div_t  last;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    a2m_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cal_code  (cal_code),
        .cal_mv    (cal_mv)
    );

    a2m_front #(
        .SEGMENTS (SEGMENTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .in_code   (adc_code),
        .cal_code  (cal_code),
        .cal_mv    (cal_mv),
        .out_valid (fr_valid),
        .out_ctrl  (fr_ctrl),
        .out_off   (fr_off),
        .out_span  (fr_span),
        .out_dmv   (fr_dmv)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= fr_valid;
    end

    always_ff @(posedge clk)
    begin
        s3_ctrl_reg <= fr_ctrl;
        s3_span_reg <= fr_span;
        s3_prod_reg <= PROD_W'(fr_dmv) * PROD_W'(fr_off);
    end

    // Upper product bits stay below the span, so the quotient fits 16 bits.
    assign chain_valid[0]     = s3_valid_reg;
    assign chain_data[0].ctrl = s3_ctrl_reg;
    assign chain_data[0].span = s3_span_reg;
    assign chain_data[0].rem  = s3_prod_reg[PROD_W-1:QBITS];
    assign chain_data[0].qn   = s3_prod_reg[QBITS-1:0];

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        a2m_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[g]),
            .in_data   (chain_data[g]),
            .out_valid (chain_valid[g+1]),
            .out_data  (chain_data[g+1])
        );
    end

    assign last = chain_data[DIV_STAGES];

    always_comb
    begin
        if (last.ctrl.below)
            mv_next = '0;
        else if (last.ctrl.above)
            mv_next = MV_TOP;
        else if (last.ctrl.neg)
            mv_next = last.ctrl.lo_mv - last.qn;
        else
            mv_next = last.ctrl.lo_mv + last.qn;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= chain_valid[DIV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        millivolts_reg <= mv_next;
    end

    assign done       = done_reg;
    assign millivolts = millivolts_reg;

endmodule

FILE: rtl/a2m_regs.sv
// Calibration table registers written through the configuration channel.
module a2m_regs (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    input  logic [2:0]              cfg_index,
    input  logic [23:0]             cfg_data,
    output a2m_pkg::code_t          cal_code [a2m_pkg::A2M_POINTS],
    output a2m_pkg::mv_t            cal_mv   [a2m_pkg::A2M_POINTS]
);
    import a2m_pkg::*;

    code_t cal_code_reg [A2M_POINTS];
    mv_t   cal_mv_reg   [A2M_POINTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < A2M_POINTS; i++)
            begin
                cal_code_reg[i] <= '0;
                cal_mv_reg[i]   <= '0;
            end
        end
        else if (cfg_valid)
        begin
            if (cfg_index < REG_MV_BASE)
                cal_code_reg[cfg_index[PT_W-1:0]] <= cfg_data;
            else
                cal_mv_reg[cfg_index[PT_W-1:0]] <= cfg_data[MV_W-1:0];
        end
    end

    assign cal_code = cal_code_reg;
    assign cal_mv   = cal_mv_reg;

endmodule

FILE: rtl/a2m_front.sv
// Segment search and operand preparation, two pipeline stages.
module a2m_front #(
    parameter int SEGMENTS = a2m_pkg::A2M_SEGMENTS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  a2m_pkg::code_t          in_code,
    input  a2m_pkg::code_t          cal_code [a2m_pkg::A2M_POINTS],
    input  a2m_pkg::mv_t            cal_mv   [a2m_pkg::A2M_POINTS],
    output logic                    out_valid,
    output a2m_pkg::ctrl_t          out_ctrl,
    output a2m_pkg::code_t          out_off,
    output a2m_pkg::code_t          out_span,
    output a2m_pkg::mv_t            out_dmv
);
    import a2m_pkg::*;

    logic             s1_valid_reg;
    code_t            s1_code_reg;
    logic             s1_below_reg;
    logic             s1_above_reg;
    logic [PT_W-1:0]  s1_seg_reg;

    logic             below_next;
    logic             found;
    logic [PT_W-1:0]  seg_next;

    logic             s2_valid_reg;
    ctrl_t            s2_ctrl_reg;
    code_t            s2_off_reg;
    code_t            s2_span_reg;
    mv_t              s2_dmv_reg;

    logic [PT_W-1:0]  seg_hi;
    code_t            lo_code;
    code_t            hi_code;
    mv_t              lo_mv;
    mv_t              hi_mv;
    logic             neg;

    // Pick the first segment whose upper code is above the input.
    always_comb
    begin
        below_next = (in_code <= cal_code[0]);
        found      = 1'b0;
        seg_next   = '0;
        for (int i = 0; i < SEGMENTS; i++)
        begin
            if (!found && (in_code < cal_code[i+1]))
            begin
                found    = 1'b1;
                seg_next = PT_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_code_reg  <= in_code;
        s1_below_reg <= below_next;
        s1_above_reg <= !found;
        s1_seg_reg   <= seg_next;
    end

    always_comb
    begin
        seg_hi  = s1_seg_reg + PT_W'(1);
        lo_code = cal_code[s1_seg_reg];
        hi_code = cal_code[seg_hi];
        lo_mv   = cal_mv[s1_seg_reg];
        hi_mv   = cal_mv[seg_hi];
        neg     = (hi_mv < lo_mv);
    end

    always_ff @(posedge clk)
    begin
        s2_ctrl_reg.below <= s1_below_reg;
        s2_ctrl_reg.above <= s1_above_reg;
        s2_ctrl_reg.neg   <= neg;
        s2_ctrl_reg.lo_mv <= lo_mv;
        s2_off_reg        <= s1_code_reg - lo_code;
        s2_span_reg       <= hi_code - lo_code;
        s2_dmv_reg        <= neg ? (lo_mv - hi_mv) : (hi_mv - lo_mv);
    end

    assign out_valid = s2_valid_reg;
    assign out_ctrl  = s2_ctrl_reg;
    assign out_off   = s2_off_reg;
    assign out_span  = s2_span_reg;
    assign out_dmv   = s2_dmv_reg;

endmodule

FILE: rtl/a2m_div_step.sv
// One stage of the restoring divider, retiring DIV_BITS quotient bits.
module a2m_div_step (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  a2m_pkg::div_t           in_data,
    output logic                    out_valid,
    output a2m_pkg::div_t           out_data
);
    import a2m_pkg::*;

    logic              valid_reg;
    div_t              data_reg;
    div_t              data_next;
    logic [CODE_W:0]   trial;

    // Shift the next numerator bit into the remainder, subtract when it fits.
    always_comb
    begin
        data_next = in_data;
        trial     = '0;
        for (int b = 0; b < DIV_BITS; b++)
        begin
            trial = {data_next.rem, data_next.qn[MV_W-1]};
            if (trial >= {1'b0, data_next.span})
            begin
                trial        = trial - {1'b0, data_next.span};
                data_next.qn = {data_next.qn[MV_W-2:0], 1'b1};
            end
            else
            begin
                data_next.qn = {data_next.qn[MV_W-2:0], 1'b0};
            end
            data_next.rem = trial[CODE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/a2m_check.sv
// Port-level checker for the converter, bound to the top level.
module a2m_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [23:0] adc_code,
    input  logic        done,
    input  logic [15:0] millivolts,
    input  logic        cfg_ready
);
    import a2m_pkg::*;

    a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_STAGES done)
        else $error("transaction result missing");

    a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_STAGES))
        else $error("result without transaction");

    a_zero_code: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(start && (adc_code == 24'd0), PIPE_STAGES)) |-> (millivolts == 16'd0))
        else $error("code zero not mapped to zero");

    a_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && cfg_ready))
        else $error("block stalled");

endmodule

bind adc_to_millivolt_piecewise_linear a2m_check u_a2m_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .adc_code   (adc_code),
    .done       (done),
    .millivolts (millivolts),
    .cfg_ready  (cfg_ready)
);

FILE: tb/testbench.sv
// Testbench for the ADC code to millivolt piecewise linear converter.
`timescale 1ns / 1ps

class mv_scoreboard;
    logic [15:0] pending_mv[$];
    int          mismatches;

    function void note_code(logic [15:0] mv);
        pending_mv.push_back(mv);
    endfunction

    function void check_mv(logic [15:0] got);
        logic [15:0] want;
        if (pending_mv.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: millivolts=%0d", got);
            return;
        end
        want = pending_mv.pop_front();
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("millivolts mismatch: expected %0d, got %0d", want, got);
        end
    endfunction
endclass

module testbench;
    import a2m_pkg::*;

    localparam int REG_CODE0 = 0;
    localparam int REG_CODE1 = 1;
    localparam int REG_CODE2 = 2;
    localparam int REG_CODE3 = 3;
    localparam int REG_MV0   = 4;
    localparam int REG_MV1   = 5;
    localparam int REG_MV2   = 6;
    localparam int REG_MV3   = 7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [23:0] adc_code = '0;
    logic        done;
    logic [15:0] millivolts;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    logic [23:0] tbl_code[4];
    logic [15:0] tbl_mv[4];
    mv_scoreboard sb;
    bit          timed_out;

    adc_to_millivolt_piecewise_linear dut (.*);

    always #1 clk = ~clk;

    function automatic logic [15:0] code_to_mv(logic [23:0] code);
        longint lo_c, hi_c, lo_v, hi_v, span, r;
        if (code <= tbl_code[0])
            return 16'd0;
        for (int i = 0; i < 3; i++)
        begin
            if (code < tbl_code[i+1])
            begin
                lo_c = tbl_code[i];
                hi_c = tbl_code[i+1];
                lo_v = tbl_mv[i];
                hi_v = tbl_mv[i+1];
                span = hi_c - lo_c;
                if (span == 0)
                    return tbl_mv[i];
                r = lo_v + ((hi_v - lo_v) * (longint'(code) - lo_c)) / span;
                if (r < 0)
                    r = 0;
                if (r > 65535)
                    r = 65535;
                return r[15:0];
            end
        end
        return MV_TOP;
    endfunction

    always @(posedge clk)
        if (rst_n && done)
            sb.check_mv(millivolts);

    // leave valid high so back-to-back writes drive it once per edge
    task automatic write_reg(int idx, logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx[2:0];
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx < 4)
            tbl_code[idx] = val;
        else
            tbl_mv[idx-4] = val[15:0];
    endtask

    // wait for the pipeline to drain before touching the table
    task automatic drain();
        int guard;
        guard = 0;
        while (sb.pending_mv.size() != 0 && guard < 10000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (PIPE_STAGES + 4) @(posedge clk);
    endtask

    task automatic load_table(logic [23:0] c0, logic [23:0] c1, logic [23:0] c2,
                              logic [23:0] c3, logic [15:0] v0, logic [15:0] v1,
                              logic [15:0] v2, logic [15:0] v3);
        drain();
        write_reg(REG_CODE0, c0);
        write_reg(REG_CODE1, c1);
        write_reg(REG_CODE2, c2);
        write_reg(REG_CODE3, c3);
        write_reg(REG_MV0, 24'(v0));
        write_reg(REG_MV1, 24'(v1));
        write_reg(REG_MV2, 24'(v2));
        write_reg(REG_MV3, 24'(v3));
        cfg_valid <= 1'b0;
    endtask

    task automatic send_code(logic [23:0] code, bit gaps);
        int idle;
        idle = gaps ? $urandom_range(0, 4) : 0;
        if (idle > 0)
        begin
            start <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        start    <= 1'b1;
        adc_code <= code;
        do
            @(posedge clk);
        while (busy);
        sb.note_code(code_to_mv(code));
    endtask

    task automatic finish_burst();
        start <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [23:0] near_point();
        int k;
        k = $urandom_range(0, 3);
        return tbl_code[k] + 24'($urandom_range(0, 4)) - 24'd2;
    endfunction

    task automatic random_phase(int count);
        bit gaps;
        logic [23:0] code;
        gaps = 1'b1;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 40) == 0)
                gaps = ~gaps;
            case ($urandom_range(0, 5))
                0: code = 24'($urandom());
                1: code = near_point();
                default:
                begin
                    code = tbl_code[$urandom_range(0, 2)];
                    code = code + 24'($urandom() % (32'(tbl_code[3] - code) + 2));
                end
            endcase
            send_code(code, gaps);
        end
        finish_burst();
    endtask

    initial
    begin
        sb = new();
        for (int i = 0; i < 4; i++)
        begin
            tbl_code[i] = '0;
            tbl_mv[i]   = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset table: code zero falls below the table, the other codes above it
        send_code(24'd0, 1'b0);
        send_code(24'hFFFFFF, 1'b0);
        send_code(24'd5, 1'b0);
        finish_burst();

        load_table(24'd1000, 24'd2000, 24'd4000, 24'd8000,
                   16'd100, 16'd600, 16'd500, 16'd9000);
        foreach (tbl_code[i])
        begin
            send_code(tbl_code[i], 1'b0);
            send_code(tbl_code[i] + 24'd1, 1'b0);
            send_code(tbl_code[i] - 24'd1, 1'b0);
        end
        send_code(24'd0, 1'b0);
        send_code(24'hFFFFFF, 1'b0);
        send_code(24'd3000, 1'b1);
        send_code(24'd6000, 1'b1);
        finish_burst();

        // extreme table with full-range codes and values, falling segment
        load_table(24'd0, 24'd1, 24'hFFFFFE, 24'hFFFFFF,
                   16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
        send_code(24'd1, 1'b0);
        send_code(24'h800000, 1'b0);
        send_code(24'hFFFFFE, 1'b0);
        send_code(24'hFFFFFF, 1'b0);
        send_code(24'h555555, 1'b0);
        send_code(24'hAAAAAA, 1'b0);
        finish_burst();

        // unsorted codes with a repeated point exercise the segment search edge cases
        load_table(24'd500, 24'd300, 24'd900, 24'd900,
                   16'd10, 16'd20, 16'd30, 16'd40);
        random_phase(150);

        load_table(24'd100, 24'd200000, 24'd3000000, 24'hF00000,
                   16'd0, 16'd12000, 16'd11000, 16'hFFFF);
        random_phase(300);
        // hold off until everything has come back
        drain();

        for (int p = 0; p < 4; p++)
        begin
            logic [23:0] c[4];
            for (int i = 0; i < 4; i++)
                c[i] = 24'($urandom());
            c.sort();
            load_table(c[0], c[1], c[2], c[3], 16'($urandom()), 16'($urandom()),
                       16'($urandom()), 16'($urandom()));
            random_phase(160);
        end

        drain();
        if (sb.mismatches == 0 && sb.pending_mv.size() == 0 && !timed_out)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial
    begin
        #200000;
        timed_out = 1'b1;
        $display("testbench failed");
        $finish;
    end
endmodule
